[rtl/security_record_block_codec_defines.svh]
// Assertion macros used by the top level of the record block codec RTL.
`ifndef SECURITY_RECORD_BLOCK_CODEC_DEFINES_SVH
`define SECURITY_RECORD_BLOCK_CODEC_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define SRBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define SRBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/srbc_pkg.sv]
// Types, tables and round functions of the record block codec.
`timescale 1ns / 1ps
package srbc_pkg;

    localparam int LANES  = 12;
    localparam int ROUNDS = 11;
    localparam int RIDX_W = $clog2(ROUNDS + 1);

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    localparam logic [1:0] MODE_MSID    = 2'd0;
    localparam logic [1:0] MODE_FLASH   = 2'd1;
    localparam logic [1:0] MODE_SIMLOCK = 2'd2;
    localparam logic [1:0] MODE_IMEI    = 2'd3;

    localparam logic [7:0] SEL_A = 8'h81;
    localparam logic [7:0] SEL_B = 8'h82;
    localparam logic [7:0] SEL_C = 8'h83;

    // lane 0 is the most significant byte
    typedef logic [0:LANES-1][7:0] lanes_t;

    typedef struct packed {
        logic   cmd;
        logic   ok;
        lanes_t tab;
        lanes_t blk;
    } srbc_item_t;

    typedef struct packed {
        logic       valid;
        srbc_item_t item;
    } srbc_stage_t;

    localparam lanes_t KEY_ENC = 96'hB173E65AAB478E0D1A34680B;
    localparam lanes_t KEY_DEC = 96'hD0162C58B071E2D55A67CE8D;

    // destination lanes fed by each source lane
    localparam logic [3:0] SPREAD [LANES][5] = '{
        '{4'd1, 4'd4, 4'd8, 4'd9, 4'd11}, '{4'd5, 4'd6, 4'd10, 4'd8, 4'd9},
        '{4'd3, 4'd1, 4'd6, 4'd10, 4'd11}, '{4'd0, 4'd7, 4'd8, 4'd10, 4'd11},
        '{4'd0, 4'd1, 4'd3, 4'd5, 4'd8}, '{4'd2, 4'd0, 4'd1, 4'd9, 4'd10},
        '{4'd2, 4'd3, 4'd5, 4'd7, 4'd10}, '{4'd0, 4'd2, 4'd3, 4'd4, 4'd11},
        '{4'd0, 4'd4, 4'd5, 4'd7, 4'd9}, '{4'd1, 4'd2, 4'd4, 4'd5, 4'd6},
        '{4'd2, 4'd6, 4'd7, 4'd9, 4'd11}, '{4'd3, 4'd4, 4'd6, 4'd7, 4'd8}
    };

    // selector low bits: 0x81 -> 01, 0x82 -> 10, 0x83 -> 11
    function automatic lanes_t lane_table(input logic [1:0] mode, input logic [1:0] sel);
        lanes_t t;
        t = '0;
        case (mode)
            MODE_MSID: begin
                case (sel)
                    SEL_B[1:0]: t = 96'h9F7AAD34E77927734E410D26;
                    SEL_C[1:0]: t = 96'h50F36525D2B1C1B609AEFF4C;
                    default:    t = 96'h83CB7424DFF1E9976871DB44;
                endcase
            end
            MODE_FLASH: begin
                case (sel)
                    SEL_B[1:0]: t = 96'h4FB96C2702DD77DD06E3E2DF;
                    SEL_C[1:0]: t = 96'hB8338004B848851A2DCEA128;
                    default:    t = 96'h2C036F345D23C658030952C4;
                endcase
            end
            MODE_SIMLOCK: begin
                case (sel)
                    SEL_B[1:0]: t = 96'hD1A25FEB4FF02D7B0F4CE1C3;
                    default:    t = 96'h7BB4D0EF9EB20ABE73DAD335;
                endcase
            end
            default: begin
                case (sel)
                    SEL_B[1:0]: t = 96'h0BAEFC8CC7FC792AC194C237;
                    default:    t = 96'hCA635AE719FAA64C0D78FC16;
                endcase
            end
        endcase
        return t;
    endfunction

    function automatic logic [7:0] round_key(input logic cmd, input logic [RIDX_W-1:0] r);
        logic [7:0] k;
        if (cmd == CMD_DECODE)
            k = KEY_DEC[r];
        else
            k = KEY_ENC[r];
        return k;
    endfunction

    function automatic lanes_t key_mix(input lanes_t b, input lanes_t t, input logic [7:0] k);
        lanes_t o;
        o = b ^ t;
        o[2] = o[2] ^ k;
        o[3] = o[3] ^ k;
        o[8] = o[8] ^ k;
        o[9] = o[9] ^ k;
        return o;
    endfunction

    function automatic lanes_t scatter(input lanes_t b);
        lanes_t     w;
        logic [7:0] all;
        w   = '0;
        all = '0;
        for (int s = 0; s < LANES; s++) begin
            all = all ^ b[s];
            for (int j = 0; j < 5; j++)
                w[SPREAD[s][j]] = w[SPREAD[s][j]] ^ b[s];
        end
        for (int s = 0; s < LANES; s++)
            w[s] = w[s] ^ all;
        return w;
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] k);
        return (x >> k) | (x << (6'd32 - {1'b0, k}));
    endfunction

    function automatic lanes_t mix_or(input lanes_t c);
        lanes_t o;
        int     j4;
        int     j8;
        for (int i = 0; i < LANES; i++) begin
            j4 = i + 4;
            if (j4 >= LANES) j4 = j4 - LANES;
            j8 = i + 8;
            if (j8 >= LANES) j8 = j8 - LANES;
            o[i] = c[i] ^ (c[j4] | ~c[j8]);
        end
        return o;
    endfunction

    // one full round: key, scatter, rotations, mix, rotations
    function automatic lanes_t full_round(input lanes_t b, input lanes_t t,
                                          input logic [7:0] k);
        lanes_t x;
        x = scatter(key_mix(b, t, k));
        x[0:3]  = rotr32(x[0:3], 5'd10);
        x[8:11] = rotr32(x[8:11], 5'd31);
        x = mix_or(x);
        x[8:11] = rotr32(x[8:11], 5'd10);
        x[0:3]  = rotr32(x[0:3], 5'd31);
        return x;
    endfunction

    // byte order reversal plus bit reversal per byte is a full bit reversal
    function automatic lanes_t bit_reverse(input lanes_t b);
        logic [8*LANES-1:0] v;
        logic [8*LANES-1:0] o;
        v = b;
        for (int i = 0; i < 8 * LANES; i++)
            o[i] = v[8 * LANES - 1 - i];
        return o;
    endfunction

endpackage

[rtl/srbc_round_cell.sv]
// One full round of the codec network with its stage register.
`timescale 1ns / 1ps
module srbc_round_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic [srbc_pkg::RIDX_W-1:0]  round_idx,
    input  srbc_pkg::srbc_stage_t        stage_in,
    output srbc_pkg::srbc_stage_t        stage_out
);
    import srbc_pkg::*;

    logic       valid_reg;
    srbc_item_t item_reg;
    srbc_item_t item_next;

    always_comb
    begin
        item_next     = stage_in.item;
        item_next.blk = full_round(stage_in.item.blk, stage_in.item.tab,
                                   round_key(stage_in.item.cmd, round_idx));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign stage_out.valid = valid_reg;
    assign stage_out.item  = item_reg;

endmodule

[rtl/srbc_final_cell.sv]
// Final half round, bit reversal and the output register.
`timescale 1ns / 1ps
module srbc_final_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  srbc_pkg::srbc_stage_t stage_in,
    output logic                  out_valid,
    output logic [63:0]           result_high,
    output logic [31:0]           result_low,
    output logic                  ok
);
    import srbc_pkg::*;

    logic        out_valid_reg;
    logic [95:0] result_reg;
    logic [95:0] result_next;
    logic        ok_reg;
    lanes_t      half;

    always_comb
    begin
        half = scatter(key_mix(stage_in.item.blk, stage_in.item.tab,
                               round_key(stage_in.item.cmd, RIDX_W'(ROUNDS))));
        // rejected selector gives an all-zero result
        result_next = stage_in.item.ok ? 96'(bit_reverse(half)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
            ok_reg     <= stage_in.item.ok;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_high = result_reg[95:32];
    assign result_low  = result_reg[31:0];
    assign ok          = ok_reg;

endmodule

[rtl/security_record_block_codec.sv]
// Top level of the record block codec: entry logic, round chain, output stage.
`timescale 1ns / 1ps
`include "security_record_block_codec_defines.svh"
// Record block codec. Each input transfer carries one 96-bit record block
// (block_high holds bytes 0..7, block_low bytes 8..11, byte 0 most
// significant), a command (encode or decode), a selector byte (0x81..0x83)
// and a record mode. The block picks a 12-byte lane table, folds the handset
// serial into lanes 0..3 when encoding in flash, simlock or imei mode, and
// runs eleven keyed rounds plus a final half round and a full bit reversal.
// Decode always uses the msid table and the decode key schedule. An unknown
// selector still travels through the chain and comes out with ok=0 and a
// zero result. Throughput: one block per clock while the chain is not held.
// A block passes through the registers of the eleven round cells and then
// the final cell, which is also the output register. The whole chain moves
// together and holds only while the output register is full and out_ready
// is low, so in_ready follows out_ready in that case. handset_serial is
// written through the cfg channel, which is always ready; write it only
// while no block is in flight.
module security_record_block_codec (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [7:0]  algo_select,
    input  logic [1:0]  record_mode,
    input  logic [63:0] block_high,
    input  logic [31:0] block_low,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_high,
    output logic [31:0] result_low,
    output logic        ok
);
    import srbc_pkg::*;

    logic [31:0]  serial_reg;
    logic         advance;
    logic [1:0]   eff_mode;
    srbc_stage_t  entry;
    srbc_stage_t  stage [0:ROUNDS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            serial_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            serial_reg <= cfg_data;
        end
    end

    // whole chain shifts unless a finished result is waiting and out_ready is low
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    // entry: table choice and serial folding
    always_comb
    begin
        eff_mode = (command == CMD_DECODE) ? MODE_MSID : record_mode;

        entry.valid    = in_valid;
        entry.item.cmd = command;
        entry.item.ok  = (algo_select inside {SEL_A, SEL_B, SEL_C});
        entry.item.tab = lane_table(eff_mode, algo_select[1:0]);
        entry.item.blk = {block_high, block_low};

        if (command == CMD_ENCODE && eff_mode != MODE_MSID)
        begin
            entry.item.tab[0] = entry.item.tab[0] ^ serial_reg[31:24];
            entry.item.tab[1] = entry.item.tab[1] ^ serial_reg[23:16];
            entry.item.tab[2] = entry.item.tab[2] ^ serial_reg[15:8];
            entry.item.tab[3] = entry.item.tab[3] ^ serial_reg[7:0];
        end
    end

    assign stage[0] = entry;

    // eleven full-round cells, each handing its block to the next
    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        srbc_round_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .round_idx (RIDX_W'(r)),
            .stage_in  (stage[r]),
            .stage_out (stage[r+1])
        );
    end

    srbc_final_cell u_final (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .stage_in    (stage[ROUNDS]),
        .out_valid   (out_valid),
        .result_high (result_high),
        .result_low  (result_low),
        .ok          (ok)
    );

    // checks
    `SRBC_ASSERT_NOW(a_reject_zero, out_valid && !ok, result_high == '0 && result_low == '0, "rejected block has a nonzero result")
    `SRBC_ASSERT_NEXT(a_entry_loaded, in_valid && in_ready, stage[1].valid, "accepted block missing from first cell")
    `SRBC_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready, "input stalled without a waiting result")

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the record block codec: directed and random blocks.
`timescale 1ns / 1ps
module tb_top;
    import srbc_pkg::*;

    localparam int  HALF_PERIOD  = 5;
    localparam int  RESET_CYCLES = 6;
    localparam int  DRAIN_CYCLES = 24;       // pipeline is 12 deep, leave margin
    localparam int  TIMEOUT_NS   = 10_000_000;
    localparam int  ROT_SHORT    = 10;
    localparam int  ROT_LONG     = 31;
    localparam int  PHASE_ITEMS  = 350;
    localparam int  STEADY_ITEMS = 100;

    // round key schedules, lane 0 in the top byte, one key byte per round
    localparam logic [95:0] ENC_KEYS = 96'hB173E65AAB478E0D1A34680B;
    localparam logic [95:0] DEC_KEYS = 96'hD0162C58B071E2D55A67CE8D;

    typedef struct packed {
        logic [63:0] hi;
        logic [31:0] lo;
        logic        ok;
    } coded_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        command = CMD_ENCODE;
    logic [7:0]  algo_select = '0;
    logic [1:0]  record_mode = MODE_MSID;
    logic [63:0] block_high = '0;
    logic [31:0] block_low = '0;
    logic        out_valid;
    logic        out_ready = 1'b1;
    logic [63:0] result_high;
    logic [31:0] result_low;
    logic        ok;

    // expected coded blocks, oldest first
    coded_t      expected_codes[$];
    logic [31:0] serial_copy = '0;   // our view of handset_serial
    bit          steady = 1'b0;      // no gaps and no stalls while set
    int          mismatches = 0;
    int          blocks_sent = 0;
    int          blocks_checked = 0;
    int          rejects_seen = 0;
    int          serial_writes = 0;
    int          stall_left = 0;

    security_record_block_codec dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .algo_select (algo_select),
        .record_mode (record_mode),
        .block_high  (block_high),
        .block_low   (block_low),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_high (result_high),
        .result_low  (result_low),
        .ok          (ok)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // lane table by mode and selector offset (0x81 -> 0)
    function automatic logic [95:0] lane_row(input logic [1:0] mode, input logic [1:0] idx);
        logic [95:0] t;
        t = '0;
        case ({mode, idx})
            {MODE_MSID, 2'd0}:    t = 96'h83CB7424DFF1E9976871DB44;
            {MODE_MSID, 2'd1}:    t = 96'h9F7AAD34E77927734E410D26;
            {MODE_MSID, 2'd2}:    t = 96'h50F36525D2B1C1B609AEFF4C;
            {MODE_FLASH, 2'd0}:   t = 96'h2C036F345D23C658030952C4;
            {MODE_FLASH, 2'd1}:   t = 96'h4FB96C2702DD77DD06E3E2DF;
            {MODE_FLASH, 2'd2}:   t = 96'hB8338004B848851A2DCEA128;
            {MODE_SIMLOCK, 2'd1}: t = 96'hD1A25FEB4FF02D7B0F4CE1C3;
            {MODE_SIMLOCK, 2'd0},
            {MODE_SIMLOCK, 2'd2}: t = 96'h7BB4D0EF9EB20ABE73DAD335;
            {MODE_IMEI, 2'd1}:    t = 96'h0BAEFC8CC7FC792AC194C237;
            default:              t = 96'hCA635AE719FAA64C0D78FC16;
        endcase
        return t;
    endfunction

    // five destination lanes of each source lane, one nibble each
    function automatic logic [19:0] spread_row(input int s);
        logic [19:0] d;
        case (s)
            0:       d = 20'h1489B;
            1:       d = 20'h56A89;
            2:       d = 20'h316AB;
            3:       d = 20'h078AB;
            4:       d = 20'h01358;
            5:       d = 20'h2019A;
            6:       d = 20'h2357A;
            7:       d = 20'h0234B;
            8:       d = 20'h04579;
            9:       d = 20'h12456;
            10:      d = 20'h2679B;
            default: d = 20'h34678;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] x, input int k);
        return (x >> k) | (x << (32 - k));
    endfunction

    function automatic logic [7:0] flip8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
            r[7 - i] = v[i];
        return r;
    endfunction

    function automatic coded_t codec_predict(input logic cmd, input logic [7:0] sel,
                                             input logic [1:0] mode, input logic [63:0] hi,
                                             input logic [31:0] lo, input logic [31:0] serial);
        coded_t      res;
        logic [95:0] tab;
        logic [95:0] keys;
        logic [95:0] blk;
        logic [95:0] flat;
        logic [7:0]  b [0:LANES-1];
        logic [7:0]  t [0:LANES-1];
        logic [7:0]  c [0:LANES-1];
        logic [7:0]  w [0:LANES-1];
        logic [7:0]  all;
        logic [7:0]  k;
        logic [1:0]  m;
        logic [7:0]  offs;
        logic [19:0] row;
        logic [31:0] x;
        res.hi = '0;
        res.lo = '0;
        res.ok = 1'b0;
        if (sel < SEL_A || sel > SEL_C)
            return res;
        m    = (cmd == CMD_DECODE) ? MODE_MSID : mode;
        offs = sel - SEL_A;
        tab  = lane_row(m, offs[1:0]);
        if (cmd == CMD_ENCODE && m != MODE_MSID)
            tab[95:64] = tab[95:64] ^ serial;
        keys = (cmd == CMD_DECODE) ? DEC_KEYS : ENC_KEYS;
        blk  = {hi, lo};
        for (int i = 0; i < LANES; i++) begin
            b[i] = blk[95 - 8 * i -: 8];
            t[i] = tab[95 - 8 * i -: 8];
        end
        // eleven full rounds, then key and scatter only
        for (int r = 0; r <= ROUNDS; r++) begin
            k = keys[95 - 8 * r -: 8];
            for (int i = 0; i < LANES; i++)
                b[i] = b[i] ^ t[i];
            b[2] = b[2] ^ k;
            b[3] = b[3] ^ k;
            b[8] = b[8] ^ k;
            b[9] = b[9] ^ k;
            all = '0;
            for (int i = 0; i < LANES; i++)
                w[i] = '0;
            for (int s = 0; s < LANES; s++) begin
                all = all ^ b[s];
                row = spread_row(s);
                for (int j = 0; j < 5; j++)
                    w[row[19 - 4 * j -: 4]] = w[row[19 - 4 * j -: 4]] ^ b[s];
            end
            for (int i = 0; i < LANES; i++)
                b[i] = w[i] ^ all;
            if (r < ROUNDS) begin
                x = ror32({b[0], b[1], b[2], b[3]}, ROT_SHORT);
                {b[0], b[1], b[2], b[3]} = x;
                x = ror32({b[8], b[9], b[10], b[11]}, ROT_LONG);
                {b[8], b[9], b[10], b[11]} = x;
                for (int i = 0; i < LANES; i++)
                    c[i] = b[i];
                for (int i = 0; i < LANES; i++)
                    b[i] = c[i] ^ (c[(i + 4) % LANES] | ~c[(i + 8) % LANES]);
                x = ror32({b[8], b[9], b[10], b[11]}, ROT_SHORT);
                {b[8], b[9], b[10], b[11]} = x;
                x = ror32({b[0], b[1], b[2], b[3]}, ROT_LONG);
                {b[0], b[1], b[2], b[3]} = x;
            end
        end
        // byte order and bit order both reversed
        for (int i = 0; i < LANES; i++)
            flat[95 - 8 * i -: 8] = flip8(b[LANES - 1 - i]);
        res.hi = flat[95:32];
        res.lo = flat[31:0];
        res.ok = 1'b1;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic logic [63:0] rand_word64();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 64'h1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] rand_word32();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at %0t, result %0d, %s: got %h expected %h",
                 $realtime, blocks_checked, what, got, want);
        mismatches++;
    endtask

    // One input transfer. Valid stays up into the next call when there is no gap.
    task automatic send_block(input logic cmd, input logic [7:0] sel, input logic [1:0] mode,
                              input logic [63:0] hi, input logic [31:0] lo);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        command     <= cmd;
        algo_select <= sel;
        record_mode <= mode;
        block_high  <= hi;
        block_low   <= lo;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_codes.push_back(codec_predict(cmd, sel, mode, hi, lo, serial_copy));
        blocks_sent++;
    endtask

    // stop sending and wait for every outstanding block to come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_codes.size() != 0)
            @(posedge clk);
    endtask

    // serial is only changed with the pipeline empty
    task automatic write_serial(input logic [31:0] value);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        serial_copy = value;
        serial_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // serial still at its reset value, so the serial fold is a no-op
    task automatic test_reset_serial();
        send_block(CMD_ENCODE, SEL_A, MODE_FLASH, 64'h0123456789ABCDEF, 32'h89ABCDEF);
        send_block(CMD_ENCODE, SEL_B, MODE_SIMLOCK, '0, '0);
        send_block(CMD_ENCODE, SEL_C, MODE_IMEI, '1, '1);
    endtask

    // every selector in every mode, with extreme and patterned blocks
    task automatic test_selectors_and_modes();
        logic [7:0]  sel;
        logic [63:0] hi;
        logic [31:0] lo;
        for (int s = 0; s < 3; s++) begin
            for (int m = 0; m < 4; m++) begin
                sel = SEL_A + 8'(s);
                case ((s * 4 + m) % 3)
                    0:       begin hi = '0;                    lo = '0;           end
                    1:       begin hi = '1;                    lo = '1;           end
                    default: begin hi = 64'hA5A55A5AF00F0FF0;  lo = 32'h3C3CC3C3; end
                endcase
                send_block(CMD_ENCODE, sel, m[1:0], hi, lo);
            end
        end
    endtask

    // decode ignores the mode and never applies the serial
    task automatic test_decode();
        send_block(CMD_DECODE, SEL_A, MODE_MSID, 64'hFEDCBA9876543210, 32'h0F1E2D3C);
        send_block(CMD_DECODE, SEL_B, MODE_FLASH, '1, '0);
        send_block(CMD_DECODE, SEL_C, MODE_SIMLOCK, '0, '1);
        send_block(CMD_DECODE, SEL_A, MODE_IMEI, 64'h8000000000000001, 32'h80000001);
    endtask

    // selectors just outside the valid range and at the byte extremes
    task automatic test_bad_selector();
        send_block(CMD_ENCODE, 8'h00, MODE_FLASH, '1, '1);
        send_block(CMD_DECODE, 8'h80, MODE_MSID, 64'h0123456789ABCDEF, 32'h01234567);
        send_block(CMD_ENCODE, 8'h84, MODE_IMEI, '0, '0);
        send_block(CMD_DECODE, 8'hFF, MODE_SIMLOCK, '1, '0);
    endtask

    // mostly valid selectors, some arbitrary bytes; drain now and then
    task automatic test_random_traffic(input int count);
        logic [7:0] sel;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 82)
                sel = SEL_A + 8'($urandom_range(0, 2));
            else
                sel = 8'($urandom_range(0, 255));
            send_block(1'($urandom_range(0, 1)), sel, 2'($urandom_range(0, 3)),
                       rand_word64(), rand_word32());
            if (n % 97 == 96)
                wait_drained();
        end
    endtask

    // full rate: no input gaps and the output always ready
    task automatic test_full_rate();
        steady = 1'b1;
        for (int n = 0; n < STEADY_ITEMS; n++)
            send_block(1'($urandom_range(0, 1)), SEL_A + 8'($urandom_range(0, 2)),
                       2'($urandom_range(0, 3)), {$urandom, $urandom}, $urandom);
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, and the scoreboard check
    // ------------------------------------------------------------------

    // out_ready drops in bursts; held high during steady stretches
    always @(negedge clk) begin
        if (steady) begin
            stall_left = 0;
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 12) begin
            stall_left = (($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                      : $urandom_range(1, 3)) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // every output transfer is matched against the oldest expected block
    always @(posedge clk) begin
        coded_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_codes.size() == 0) begin
                report_mismatch("unexpected result", result_high, '0);
            end else begin
                want = expected_codes.pop_front();
                if (result_high !== want.hi)
                    report_mismatch("result_high", result_high, want.hi);
                if (result_low !== want.lo)
                    report_mismatch("result_low", {32'd0, result_low}, {32'd0, want.lo});
                if (ok !== want.ok)
                    report_mismatch("ok", {63'd0, ok}, {63'd0, want.ok});
                if (!want.ok)
                    rejects_seen++;
            end
            blocks_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_serial();
        write_serial(32'hFFFFFFFF);
        test_selectors_and_modes();
        test_decode();
        test_bad_selector();

        write_serial($urandom);
        test_full_rate();

        // random phases across several serial settings, extremes included
        write_serial(32'h00000000);
        test_random_traffic(PHASE_ITEMS);
        write_serial($urandom);
        test_random_traffic(PHASE_ITEMS);
        write_serial(32'h80000001);
        test_random_traffic(PHASE_ITEMS);
        write_serial(32'hFFFFFFFF);
        test_random_traffic(PHASE_ITEMS);
        write_serial($urandom);
        test_random_traffic(PHASE_ITEMS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d blocks through the codec, %0d checked, %0d with a rejected selector,",
                 blocks_sent, blocks_checked, rejects_seen);
        $display("over %0d serial settings, both commands, all modes and random stalls.",
                 serial_writes);
        if (mismatches == 0 && expected_codes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog against a hung handshake
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results outstanding", expected_codes.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
